/* hw/rtl/cral_pkg.sv */
// ----------------------------------------------------------------------------
// cral_pkg
// Shared types and constants of the colour ramp age lerp block.
// ----------------------------------------------------------------------------
package cral_pkg;

  localparam int CRAL_RAMP_DEPTH = 256;
  localparam int CRAL_QUEUE_DEPTH = 4;
  localparam int CRAL_DIV_STEPS = 24;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_SHADE = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [7:0]  entry_index;
    logic [7:0]  entry_red;
    logic [7:0]  entry_green;
    logic [7:0]  entry_blue;
    logic [7:0]  entry_alpha;
    logic [15:0] remaining_life;
    logic [15:0] total_life;
  } in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } out_t;

  // one divider step: partial remainder, divisor, dividend bits still to
  // shift in and quotient so far
  typedef struct packed {
    logic        op;
    logic [7:0]  eidx;
    logic [31:0] word;
    logic [15:0] rem;
    logic [15:0] div;
    logic [7:0]  lo;
    logic [23:0] quo;
  } div_t;

  typedef struct packed {
    logic        op;
    logic [7:0]  eidx;
    logic [31:0] word;
    logic [23:0] scaled;
  } job_t;

  typedef struct packed {
    logic push;
    logic full;
    logic pop;
    logic avail;
  } qctl_t;

endpackage

/* hw/rtl/colour_ramp_age_lerp.sv */
// ----------------------------------------------------------------------------
// colour_ramp_age_lerp
// Particle colour from a one-row RGBA ramp by age, with linear blending.
// ----------------------------------------------------------------------------
// shade path: front and divider registers, queue, ramp read, blend, output
// throughput: one beat per cycle unless stalled; 24-stage pipelined divider
// loads take the same path and write the ramp in order, giving no result
// reset clears all valid state and the last index; ramp contents undefined
// ----------------------------------------------------------------------------
module colour_ramp_age_lerp #(
  parameter int RAMP_DEPTH = cral_pkg::CRAL_RAMP_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  cral_pkg::in_t    in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output cral_pkg::out_t   out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [7:0]       cfg_data
);

  logic [7:0]      last_r;
  cral_pkg::qctl_t qc;
  cral_pkg::job_t  push_data, head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      last_r <= cfg_data;
    end
  end

  cral_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .last(last_r), .q_full(qc.full), .q_push(qc.push),
    .q_data(push_data)
  );

  cral_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(qc.push), .push_data(push_data),
    .full(qc.full), .pop(qc.pop), .avail(qc.avail), .head(head)
  );

  cral_back #(.RAMP_DEPTH(RAMP_DEPTH)) u_back (
    .clk(clk), .rst_n(rst_n), .last(last_r), .q_avail(qc.avail), .q_head(head),
    .q_pop(qc.pop), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(qc.push && qc.full && !qc.pop)) else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    qc.pop |-> qc.avail) else $error("queue underflow");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("result after reset");

endmodule

/* hw/rtl/cral_ram.sv */
// ----------------------------------------------------------------------------
// cral_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module cral_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = cral_pkg::CRAL_RAMP_DEPTH
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/cral_queue.sv */
// ----------------------------------------------------------------------------
// cral_queue
// Short first-in first-out queue of jobs between front and back.
// ----------------------------------------------------------------------------
module cral_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  cral_pkg::job_t   push_data,
  output logic             full,
  input  logic             pop,
  output logic             avail,
  output cral_pkg::job_t   head
);

  localparam int D = cral_pkg::CRAL_QUEUE_DEPTH;
  localparam int PW = $clog2(D);

  cral_pkg::job_t  slot_r [D];
  logic [PW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [PW:0]     cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      slot_r[wp_r] <= push_data;
    end
  end

  assign full  = (cnt_r == (PW+1)'(D));
  assign avail = (cnt_r != '0);
  assign head  = slot_r[rp_r];

endmodule

/* hw/rtl/cral_front.sv */
// ----------------------------------------------------------------------------
// cral_front
// Takes items, forms the scaled age numerator and runs the pipelined
// restoring divider; loads ride along to keep order.
// ----------------------------------------------------------------------------
module cral_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  cral_pkg::in_t    in_data,
  input  logic [7:0]       last,
  input  logic             q_full,
  output logic             q_push,
  output cral_pkg::job_t   q_data
);

  localparam int N = cral_pkg::CRAL_DIV_STEPS;

  logic           adv;
  logic           s0_v_r;
  cral_pkg::in_t  s0_r;
  logic           s1_v_r;
  cral_pkg::div_t s1_r, s1_nxt;
  logic           dv_v_r [N];
  cral_pkg::div_t dv_r   [N];
  logic [15:0]    diff, dsr;

  assign adv      = !q_full;
  assign in_ready = adv;

  always_comb begin
    if (s0_r.total_life == 16'd0) begin
      diff = 16'd1;
      dsr  = 16'd1;
    end else if (s0_r.remaining_life >= s0_r.total_life) begin
      diff = 16'd0;
      dsr  = s0_r.total_life;
    end else begin
      diff = s0_r.total_life - s0_r.remaining_life;
      dsr  = s0_r.total_life;
    end
    s1_nxt.op   = s0_r.operation;
    s1_nxt.eidx = s0_r.entry_index;
    s1_nxt.word = {s0_r.entry_alpha, s0_r.entry_blue, s0_r.entry_green, s0_r.entry_red};
    {s1_nxt.rem, s1_nxt.lo} = 24'(diff) * 24'(last);
    s1_nxt.div  = dsr;
    s1_nxt.quo  = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s0_v_r <= in_valid;
      s1_v_r <= s0_v_r;
    end
    if (adv) begin
      s0_r <= in_data;
      s1_r <= s1_nxt;
    end
  end

  genvar k;
  generate
    for (k = 0; k < N; k++) begin : g_div
      cral_pkg::div_t prv, nxt;
      logic           pv;
      logic [16:0]    t;
      logic           ge;
      if (k == 0) begin : g_first
        assign prv = s1_r;
        assign pv  = s1_v_r;
      end else begin : g_rest
        assign prv = dv_r[k-1];
        assign pv  = dv_v_r[k-1];
      end
      always_comb begin
        t        = {prv.rem, prv.lo[7]};
        ge       = (t >= {1'b0, prv.div});
        nxt      = prv;
        nxt.rem  = ge ? 16'(t - {1'b0, prv.div}) : t[15:0];
        nxt.lo   = {prv.lo[6:0], 1'b0};
        nxt.quo  = {prv.quo[22:0], ge};
      end
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          dv_v_r[k] <= 1'b0;
        end else if (adv) begin
          dv_v_r[k] <= pv;
        end
        if (adv) begin
          dv_r[k] <= nxt;
        end
      end
    end
  endgenerate

  assign q_push      = dv_v_r[N-1] && adv;
  assign q_data.op     = dv_r[N-1].op;
  assign q_data.eidx   = dv_r[N-1].eidx;
  assign q_data.word   = dv_r[N-1].word;
  assign q_data.scaled = dv_r[N-1].quo;

endmodule

/* hw/rtl/cral_back.sv */
// ----------------------------------------------------------------------------
// cral_back
// Writes ramp entries, reads the two neighbouring entries and blends the
// four channels into the output register.
// ----------------------------------------------------------------------------
module cral_back #(
  parameter int RAMP_DEPTH = cral_pkg::CRAL_RAMP_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [7:0]       last,
  input  logic             q_avail,
  input  cral_pkg::job_t   q_head,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output cral_pkg::out_t   out_data
);

  localparam int AW = (RAMP_DEPTH > 1) ? $clog2(RAMP_DEPTH) : 1;

  logic          adv;
  logic          is_end, we;
  logic [7:0]    idx, ra, rb;
  logic [15:0]   fr;
  logic [31:0]   da, db, from_w, to_w;
  logic          b1_v_r, oob_a_r, oob_b_r;
  logic [15:0]   fr_r;
  logic [16:0]   inv;
  logic          b2_v_r;
  logic [24:0]   pf_r [4];
  logic [23:0]   pt_r [4];
  logic          out_v_r;
  cral_pkg::out_t out_r;
  logic [7:0]    ch [4];

  assign adv   = !out_v_r || out_ready;
  assign q_pop = q_avail && adv;

  always_comb begin
    idx    = q_head.scaled[23:16];
    is_end = (idx >= last);
    ra     = is_end ? last : idx;
    rb     = idx + 8'd1;
    fr     = is_end ? 16'd0 : q_head.scaled[15:0];
    we     = q_pop && (q_head.op == cral_pkg::OP_LOAD)
             && (32'(q_head.eidx) < 32'(RAMP_DEPTH));
  end

  cral_ram #(.WIDTH(32), .DEPTH(RAMP_DEPTH)) u_ram_a (
    .clk(clk), .we(we), .waddr(AW'(q_head.eidx)), .wdata(q_head.word),
    .re(adv), .raddr(AW'(ra)), .rdata(da)
  );

  cral_ram #(.WIDTH(32), .DEPTH(RAMP_DEPTH)) u_ram_b (
    .clk(clk), .we(we), .waddr(AW'(q_head.eidx)), .wdata(q_head.word),
    .re(adv), .raddr(AW'(rb)), .rdata(db)
  );

  assign from_w = oob_a_r ? 32'd0 : da;
  assign to_w   = oob_b_r ? 32'd0 : db;
  assign inv    = 17'h10000 - {1'b0, fr_r};

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      ch[k] = 8'((25'(pf_r[k]) + 25'(pt_r[k]) + 25'd32768) >> 16);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r  <= 1'b0;
      b2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      b1_v_r  <= q_pop && (q_head.op == cral_pkg::OP_SHADE);
      b2_v_r  <= b1_v_r;
      out_v_r <= b2_v_r;
    end
    if (adv) begin
      oob_a_r <= (32'(ra) >= 32'(RAMP_DEPTH));
      oob_b_r <= is_end || (32'(rb) >= 32'(RAMP_DEPTH));
      fr_r    <= fr;
      for (int k = 0; k < 4; k++) begin
        pf_r[k] <= 25'(from_w[8*k +: 8]) * 25'(inv);
        pt_r[k] <= 24'(to_w[8*k +: 8]) * 24'(fr_r);
      end
      out_r.red   <= ch[0];
      out_r.green <= ch[1];
      out_r.blue  <= ch[2];
      out_r.alpha <= ch[3];
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for colour_ramp_age_lerp: a predictor tracks the ramp
// and last index and computes the blended colour of every shade beat; output
// beats are compared field by field in order, with random gaps on both sides.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 64;
  localparam longint CYCLE_LIMIT = 400000;

  class colour_board;
    logic [31:0] ramp [256];
    bit          written [256];
    logic [7:0]  last_idx;
    cral_pkg::out_t pending [$];
    int          errors;
    int          shown;

    function void clear_ramp();
      foreach (written[i]) written[i] = 1'b0;
      last_idx = 8'd0;
      errors = 0;
      shown = 0;
    endfunction

    function void note_beat(cral_pkg::in_t b);
      logic [47:0] scaled;
      logic [31:0] idx, frac, from_w, to_w;
      cral_pkg::out_t c;
      logic [31:0] v;
      if (b.operation == cral_pkg::OP_LOAD) begin
        ramp[b.entry_index] = {b.entry_alpha, b.entry_blue, b.entry_green, b.entry_red};
        written[b.entry_index] = 1'b1;
        return;
      end
      if (b.total_life == 0) scaled = {last_idx, 16'd0};
      else if (b.remaining_life >= b.total_life) scaled = 0;
      else scaled = ((48'(b.total_life - b.remaining_life) * last_idx) << 16) / b.total_life;
      idx = scaled[47:16];
      frac = {16'd0, scaled[15:0]};
      if (idx >= last_idx) begin
        from_w = ramp[last_idx];
        c = {from_w[7:0], from_w[15:8], from_w[23:16], from_w[31:24]};
      end else begin
        from_w = ramp[idx];
        to_w = ramp[idx + 1];
        for (int k = 0; k < 4; k++) begin
          v = (32'(from_w[8*k +: 8]) * (32'd65536 - frac) + 32'(to_w[8*k +: 8]) * frac
               + 32'd32768) >> 16;
          c[8*(3-k) +: 8] = v[7:0];
        end
      end
      pending.push_back(c);
    endfunction

    function void check_beat(cral_pkg::out_t got);
      cral_pkg::out_t exp_c;
      if (pending.size() == 0) begin
        errors++;
        if (shown++ < 10) $display("unexpected result beat %h", got);
        return;
      end
      exp_c = pending.pop_front();
      if (got.red !== exp_c.red || got.green !== exp_c.green ||
          got.blue !== exp_c.blue || got.alpha !== exp_c.alpha) begin
        errors++;
        if (shown++ < 10) $display("mismatch: expected %h got %h", exp_c, got);
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  cral_pkg::in_t  in_data;
  cral_pkg::out_t out_data;
  logic [7:0] cfg_data;
  colour_board board;
  longint cycles;
  bit hold_off;
  bit press_req;
  bit stim_done;

  colour_ramp_age_lerp dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic send_beat(cral_pkg::in_t b);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
    if ($urandom_range(0, 1)) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (!in_ready);
    board.note_beat(b);
  endtask

  task automatic write_last(logic [7:0] v);
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    board.last_idx = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic load_entry(logic [7:0] e, logic [31:0] w);
    cral_pkg::in_t b;
    b = cral_pkg::in_t'({$urandom, $urandom, $urandom});
    b.operation = cral_pkg::OP_LOAD;
    b.entry_index = e;
    {b.entry_alpha, b.entry_blue, b.entry_green, b.entry_red} = w;
    send_beat(b);
  endtask

  task automatic shade(logic [15:0] r, logic [15:0] t);
    cral_pkg::in_t b;
    b = cral_pkg::in_t'({$urandom, $urandom, $urandom});
    b.operation = cral_pkg::OP_SHADE;
    b.remaining_life = r;
    b.total_life = t;
    send_beat(b);
  endtask

  task automatic fill_ramp(int upto);
    for (int i = 0; i <= upto; i++) load_entry(i[7:0], $urandom);
  endtask

  task automatic random_life(output logic [15:0] r, output logic [15:0] t);
    case ($urandom_range(0, 5))
      0: begin t = 16'($urandom); r = 16'($urandom); end
      1: begin t = 16'd0; r = 16'($urandom); end
      2: begin t = 16'($urandom_range(1, 15)); r = 16'($urandom_range(0, 20)); end
      default: begin
        t = 16'($urandom_range(1, 65535));
        r = 16'($urandom_range(0, 32'(t)));
      end
    endcase
  endtask

  task automatic random_phase(logic [7:0] last, int count);
    logic [15:0] r, t;
    write_last(last);
    fill_ramp(last);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) == 0) load_entry(8'($urandom_range(0, 32'(last))), $urandom);
      else if ($urandom_range(0, 29) == 0) load_entry(8'($urandom_range(0, 255)), $urandom);
      else begin
        random_life(r, t);
        shade(r, t);
      end
    end
  endtask

  // receiver: random stalls plus one long hold-off
  initial begin
    int wait_c;
    wait_c = 0;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        board.check_beat(out_data);
        wait_c = $urandom_range(0, 1) ? $urandom_range(0, 16) : 0;
      end
      if (hold_off) begin
        out_ready <= 1'b0;
      end else if (wait_c > 0) begin
        out_ready <= 1'b0;
        wait_c--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    hold_off = 1'b0;
    do @(posedge clk); while (!(press_req && board.pending.size() != 0));
    hold_off = 1'b1;
    repeat (400) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    board = new();
    board.clear_ramp();
    stim_done = 1'b0;
    press_req = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: last index zero, zero total life, remaining past total, extremes
    load_entry(8'd0, 32'hFFFF_FFFF);
    shade(16'd0, 16'd0);
    shade(16'd5, 16'd100);
    write_last(8'd255);
    fill_ramp(255);
    load_entry(8'd0, 32'h0000_0000);
    load_entry(8'd1, 32'hFFFF_FFFF);
    shade(16'd0, 16'd0);
    shade(16'hFFFF, 16'hFFFF);
    shade(16'hFFFF, 16'd1);
    shade(16'd0, 16'hFFFF);
    shade(16'd1, 16'hFFFF);
    shade(16'hFFFE, 16'hFFFF);
    shade(16'd32768, 16'd65535);
    shade(16'd0, 16'd1);
    shade(16'd1, 16'd3);
    load_entry(8'd255, 32'h8040_20AA);
    shade(16'd0, 16'd7);
    random_phase(8'd1, 60);
    press_req = 1'b1;
    random_phase(8'd255, 150);
    random_phase(8'd0, 30);
    random_phase(8'($urandom_range(2, 254)), 100);
    random_phase(8'($urandom_range(2, 20)), 80);
    stim_done = 1'b1;
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

/* filelist.f */
hw/rtl/cral_pkg.sv
hw/rtl/cral_ram.sv
hw/rtl/cral_queue.sv
hw/rtl/cral_front.sv
hw/rtl/cral_back.sv
hw/rtl/colour_ramp_age_lerp.sv
tb/tb.sv
